/* rtl/md5sh_pkg.sv */
package md5sh_pkg;

	// Input item: append one byte or finish the message.
	typedef struct packed {
		logic       func;
		logic [7:0] data_byte;
	} md5sh_in_t;

	// Result item: one digest word.
	typedef struct packed {
		logic [31:0] digest_word;
		logic [1:0]  word_index;
		logic        last_word;
	} md5sh_out_t;

	// Function codes of an input item.
	localparam logic FUNC_APPEND = 1'b0;
	localparam logic FUNC_FINISH = 1'b1;

	// Source of the byte written into the block buffer.
	localparam logic [1:0] SEL_DATA = 2'd0;
	localparam logic [1:0] SEL_PAD  = 2'd1;
	localparam logic [1:0] SEL_ZERO = 2'd2;
	localparam logic [1:0] SEL_LEN  = 2'd3;

	localparam logic [7:0] PAD_BYTE = 8'h80;

	// Initial chaining values.
	localparam logic [31:0] INIT_A = 32'h67452301;
	localparam logic [31:0] INIT_B = 32'hefcdab89;
	localparam logic [31:0] INIT_C = 32'h98badcfe;
	localparam logic [31:0] INIT_D = 32'h10325476;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       wr_en;     // write one byte at the fill position
		logic [1:0] byte_sel;  // which byte is written
		logic       count_en;  // add one byte to the message length
		logic       start;     // load the working words from the chaining words
		logic       round_en;  // run one compression round
		logic [5:0] rnd;       // round number
		logic       fold;      // add the working words into the chaining words
		logic       emit;      // load one digest word into the output register
		logic [1:0] emit_idx;  // which digest word
		logic       clear;     // return to the initial message state
	} md5sh_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [5:0] pos;       // next byte position in the block buffer
		logic       out_free;  // output register can take a word this cycle
	} md5sh_sts_t;

	// Per-round additive constants.
	function automatic logic [31:0] md5_k(input logic [5:0] i);
		logic [31:0] k;
		case (i)
			6'd0:  k = 32'hd76aa478;
			6'd1:  k = 32'he8c7b756;
			6'd2:  k = 32'h242070db;
			6'd3:  k = 32'hc1bdceee;
			6'd4:  k = 32'hf57c0faf;
			6'd5:  k = 32'h4787c62a;
			6'd6:  k = 32'ha8304613;
			6'd7:  k = 32'hfd469501;
			6'd8:  k = 32'h698098d8;
			6'd9:  k = 32'h8b44f7af;
			6'd10: k = 32'hffff5bb1;
			6'd11: k = 32'h895cd7be;
			6'd12: k = 32'h6b901122;
			6'd13: k = 32'hfd987193;
			6'd14: k = 32'ha679438e;
			6'd15: k = 32'h49b40821;
			6'd16: k = 32'hf61e2562;
			6'd17: k = 32'hc040b340;
			6'd18: k = 32'h265e5a51;
			6'd19: k = 32'he9b6c7aa;
			6'd20: k = 32'hd62f105d;
			6'd21: k = 32'h02441453;
			6'd22: k = 32'hd8a1e681;
			6'd23: k = 32'he7d3fbc8;
			6'd24: k = 32'h21e1cde6;
			6'd25: k = 32'hc33707d6;
			6'd26: k = 32'hf4d50d87;
			6'd27: k = 32'h455a14ed;
			6'd28: k = 32'ha9e3e905;
			6'd29: k = 32'hfcefa3f8;
			6'd30: k = 32'h676f02d9;
			6'd31: k = 32'h8d2a4c8a;
			6'd32: k = 32'hfffa3942;
			6'd33: k = 32'h8771f681;
			6'd34: k = 32'h6d9d6122;
			6'd35: k = 32'hfde5380c;
			6'd36: k = 32'ha4beea44;
			6'd37: k = 32'h4bdecfa9;
			6'd38: k = 32'hf6bb4b60;
			6'd39: k = 32'hbebfbc70;
			6'd40: k = 32'h289b7ec6;
			6'd41: k = 32'heaa127fa;
			6'd42: k = 32'hd4ef3085;
			6'd43: k = 32'h04881d05;
			6'd44: k = 32'hd9d4d039;
			6'd45: k = 32'he6db99e5;
			6'd46: k = 32'h1fa27cf8;
			6'd47: k = 32'hc4ac5665;
			6'd48: k = 32'hf4292244;
			6'd49: k = 32'h432aff97;
			6'd50: k = 32'hab9423a7;
			6'd51: k = 32'hfc93a039;
			6'd52: k = 32'h655b59c3;
			6'd53: k = 32'h8f0ccc92;
			6'd54: k = 32'hffeff47d;
			6'd55: k = 32'h85845dd1;
			6'd56: k = 32'h6fa87e4f;
			6'd57: k = 32'hfe2ce6e0;
			6'd58: k = 32'ha3014314;
			6'd59: k = 32'h4e0811a1;
			6'd60: k = 32'hf7537e82;
			6'd61: k = 32'hbd3af235;
			6'd62: k = 32'h2ad7d2bb;
			6'd63: k = 32'heb86d391;
			default: k = 32'h0;
		endcase
		return k;
	endfunction

	// Rotate amount for a round, chosen by round group and round number mod 4.
	function automatic logic [4:0] md5_rot(input logic [1:0] grp, input logic [1:0] sub);
		logic [4:0] s;
		case ({grp, sub})
			4'd0:  s = 5'd7;
			4'd1:  s = 5'd12;
			4'd2:  s = 5'd17;
			4'd3:  s = 5'd22;
			4'd4:  s = 5'd5;
			4'd5:  s = 5'd9;
			4'd6:  s = 5'd14;
			4'd7:  s = 5'd20;
			4'd8:  s = 5'd4;
			4'd9:  s = 5'd11;
			4'd10: s = 5'd16;
			4'd11: s = 5'd23;
			4'd12: s = 5'd6;
			4'd13: s = 5'd10;
			4'd14: s = 5'd15;
			4'd15: s = 5'd21;
			default: s = 5'd0;
		endcase
		return s;
	endfunction

endpackage

/* rtl/md5sh_datapath.sv */
module md5sh_datapath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  md5sh_pkg::md5sh_cmd_t  cmd,
	input  logic [7:0]             data_byte,
	output md5sh_pkg::md5sh_sts_t  sts,
	output logic                   dig_valid,
	input  logic                   dig_ready,
	output md5sh_pkg::md5sh_out_t  dig
);
	import md5sh_pkg::*;

	// Block buffer as sixteen little-endian message words.
	logic [31:0] buf_q [16];
	logic [31:0] h_q [4];
	logic [31:0] a_q, b_q, c_q, d_q;
	logic [63:0] bit_count_q;
	logic [5:0]  pos_q;
	logic        dig_valid_q;
	md5sh_out_t  dig_q;

	logic [7:0]  wr_byte;
	logic [7:0]  len_byte;
	logic [1:0]  grp;
	logic [3:0]  r4;
	logic [3:0]  g;
	logic [31:0] f;
	logic [31:0] m;
	logic [31:0] t;
	logic [63:0] t_dbl;
	logic [4:0]  s;

	// Length byte for positions 56 to 63, least significant byte first.
	assign len_byte = bit_count_q[{pos_q[2:0], 3'b000} +: 8];

	// Byte written into the buffer.
	always_comb begin
		case (cmd.byte_sel)
			SEL_DATA: wr_byte = data_byte;
			SEL_PAD:  wr_byte = PAD_BYTE;
			SEL_ZERO: wr_byte = 8'h00;
			SEL_LEN:  wr_byte = len_byte;
			default:  wr_byte = 8'h00;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			buf_q[pos_q[5:2]][{pos_q[1:0], 3'b000} +: 8] <= wr_byte;
		end
	end

	// Fill position and message length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			bit_count_q <= '0;
		end else if (cmd.clear) begin
			pos_q       <= '0;
			bit_count_q <= '0;
		end else begin
			if (cmd.wr_en) begin
				pos_q <= pos_q + 6'd1;
			end
			if (cmd.count_en) begin
				bit_count_q <= bit_count_q + 64'd8;
			end
		end
	end

	// Round function and message word selection.
	assign grp = cmd.rnd[5:4];
	assign r4  = cmd.rnd[3:0];

	always_comb begin
		case (grp)
			2'd0: begin
				f = (b_q & c_q) | (~b_q & d_q);
				g = r4;
			end
			2'd1: begin
				f = (b_q & d_q) | (c_q & ~d_q);
				g = r4 * 4'd5 + 4'd1;
			end
			2'd2: begin
				f = b_q ^ c_q ^ d_q;
				g = r4 * 4'd3 + 4'd5;
			end
			2'd3: begin
				f = c_q ^ (b_q | ~d_q);
				g = r4 * 4'd7;
			end
			default: begin
				f = '0;
				g = '0;
			end
		endcase
	end

	assign m     = buf_q[g];
	assign t     = a_q + f + md5_k(cmd.rnd) + m;
	assign s     = md5_rot(grp, cmd.rnd[1:0]);
	assign t_dbl = {t, t} << s;

	// Working words: loaded at block start, one round per cycle.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
		end else if (cmd.round_en) begin
			a_q <= d_q;
			d_q <= c_q;
			c_q <= b_q;
			b_q <= b_q + t_dbl[63:32];
		end
	end

	// Chaining words.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q[0] <= INIT_A;
			h_q[1] <= INIT_B;
			h_q[2] <= INIT_C;
			h_q[3] <= INIT_D;
		end else if (cmd.clear) begin
			h_q[0] <= INIT_A;
			h_q[1] <= INIT_B;
			h_q[2] <= INIT_C;
			h_q[3] <= INIT_D;
		end else if (cmd.fold) begin
			h_q[0] <= h_q[0] + a_q;
			h_q[1] <= h_q[1] + b_q;
			h_q[2] <= h_q[2] + c_q;
			h_q[3] <= h_q[3] + d_q;
		end
	end

	// Output register; a word waits here until its transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			dig_valid_q <= 1'b1;
		end else if (dig_ready) begin
			dig_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			dig_q.digest_word <= h_q[cmd.emit_idx];
			dig_q.word_index  <= cmd.emit_idx;
			dig_q.last_word   <= (cmd.emit_idx == 2'd3);
		end
	end

	assign dig_valid    = dig_valid_q;
	assign dig          = dig_q;
	assign sts.pos      = pos_q;
	assign sts.out_free = !dig_valid_q || dig_ready;

endmodule

/* rtl/md5sh_ctrl.sv */
module md5sh_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   msg_valid,
	output logic                   msg_ready,
	input  logic                   func,
	input  md5sh_pkg::md5sh_sts_t  sts,
	output md5sh_pkg::md5sh_cmd_t  cmd
);
	import md5sh_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_P80   = 3'd1;
	localparam logic [2:0] ST_PZERO = 3'd2;
	localparam logic [2:0] ST_PLEN  = 3'd3;
	localparam logic [2:0] ST_RUN   = 3'd4;
	localparam logic [2:0] ST_FOLD  = 3'd5;
	localparam logic [2:0] ST_EMIT  = 3'd6;

	logic [2:0] state_q, state_d;
	logic [2:0] ret_q, ret_d;
	logic [5:0] rnd_q, rnd_d;
	logic [1:0] idx_q, idx_d;
	logic       blk_full;

	assign msg_ready = (state_q == ST_IDLE);
	assign blk_full  = (sts.pos == 6'd63);

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		rnd_d   = rnd_q;
		idx_d   = idx_q;
		cmd     = '0;
		cmd.rnd      = rnd_q;
		cmd.emit_idx = idx_q;
		case (state_q)
			ST_IDLE: begin
				if (msg_valid) begin
					if (func == FUNC_APPEND) begin
						cmd.wr_en    = 1'b1;
						cmd.byte_sel = SEL_DATA;
						cmd.count_en = 1'b1;
						if (blk_full) begin
							cmd.start = 1'b1;
							ret_d     = ST_IDLE;
							state_d   = ST_RUN;
						end
					end else begin
						state_d = ST_P80;
					end
				end
			end
			ST_P80: begin
				cmd.wr_en    = 1'b1;
				cmd.byte_sel = SEL_PAD;
				if (blk_full) begin
					cmd.start = 1'b1;
					ret_d     = ST_PZERO;
					state_d   = ST_RUN;
				end else begin
					state_d = ST_PZERO;
				end
			end
			ST_PZERO: begin
				cmd.wr_en = 1'b1;
				if (sts.pos == 6'd56) begin
					// First length byte goes out in this cycle.
					cmd.byte_sel = SEL_LEN;
					state_d      = ST_PLEN;
				end else begin
					cmd.byte_sel = SEL_ZERO;
					if (blk_full) begin
						cmd.start = 1'b1;
						ret_d     = ST_PZERO;
						state_d   = ST_RUN;
					end
				end
			end
			ST_PLEN: begin
				cmd.wr_en    = 1'b1;
				cmd.byte_sel = SEL_LEN;
				if (blk_full) begin
					cmd.start = 1'b1;
					ret_d     = ST_EMIT;
					state_d   = ST_RUN;
				end
			end
			ST_RUN: begin
				cmd.round_en = 1'b1;
				rnd_d        = rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					state_d = ST_FOLD;
				end
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				state_d  = ret_q;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					idx_d    = idx_q + 2'd1;
					if (idx_q == 2'd3) begin
						cmd.clear = 1'b1;
						state_d   = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q   <= ST_IDLE;
			rnd_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
			rnd_q   <= rnd_d;
			idx_q   <= idx_d;
		end
	end

endmodule

/* rtl/md5_stream_hasher_unit.sv */
// Streaming MD5 hasher.
// Input channel (msg_valid, msg_ready, msg): each transfer either appends
// msg.data_byte to the message or, with msg.func set, finishes the message.
// Output channel (dig_valid, dig_ready, dig): a finish yields four transfers,
// digest words 0 to 3 in order, each little-endian, last_word set on word 3.
// An append leaves msg_ready high unless it fills a 64-byte block; that
// append keeps msg_ready low through 64 compression rounds, one per cycle in a
// single round unit, and then a fold of the result into the chaining words.
// A finish writes the padding and the length one byte per cycle, pausing for
// each compression (one or two), then presents word 0; the block takes new
// input again once word 3 is loaded into the output register.
// Reset sets the initial chaining words and a zero length; the block then
// takes input at once. A stalled receiver holds the current word in the output
// register and stalls the remaining digest words, never dropping one; after a
// finish the block returns to the initial state for the next message.
module md5_stream_hasher_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  msg_valid,
	output logic                  msg_ready,
	input  md5sh_pkg::md5sh_in_t  msg,
	output logic                  dig_valid,
	input  logic                  dig_ready,
	output md5sh_pkg::md5sh_out_t dig
);
	import md5sh_pkg::*;

	md5sh_cmd_t cmd;
	md5sh_sts_t sts;

	// Sequencer for append, padding, compression and digest output.
	md5sh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_ready (msg_ready),
		.func      (msg.func),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Buffer, round unit, chaining words and output register.
	md5sh_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.data_byte (msg.data_byte),
		.sts       (sts),
		.dig_valid (dig_valid),
		.dig_ready (dig_ready),
		.dig       (dig)
	);

endmodule
